### hw/rtl/angle_pid_with_wrap_defines.svh
// Assertion macros shared by the angle PID checker.
// No dependencies; included by files that assert.
`ifndef ANGLE_PID_WITH_WRAP_DEFINES_SVH
`define ANGLE_PID_WITH_WRAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define APWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define APWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/apwr_pkg.sv
// Shared types and constants of the angle PID with wrapped error.
// No dependencies; used by every module of the block.
package apwr_pkg;

  localparam int AngleW   = 16;
  localparam int GainW    = 16;
  localparam int LimitW   = 31;
  localparam int DriveW   = 32;
  localparam int GainFrac = 8;
  localparam int TermW    = AngleW + GainW + 1 - GainFrac;  // shifted product width
  localparam int CfgIdxW  = 3;

  localparam logic signed [AngleW:0] AnglePi    = 17'sd25736;
  localparam logic signed [AngleW:0] AngleTwoPi = 17'sd51472;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegPropGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntegLim  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutLim    = 3'd4;

  // Gains and limits handed to the datapath
  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  integ_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [LimitW-1:0] integral_limit;
    logic [LimitW-1:0] output_limit;
  } cfg_t;

  // Product stage result, one per item
  typedef struct packed {
    logic                     clear_loop;
    logic signed [AngleW-1:0] err;
    logic signed [TermW-1:0]  p_term;
    logic signed [TermW-1:0]  i_term;
    logic signed [TermW-1:0]  d_term;
  } term_t;

endpackage

### hw/rtl/apwr_term.sv
// Error wrap and the three gain products, registered.
// Depends on apwr_pkg.
module apwr_term (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [apwr_pkg::AngleW-1:0] measured_angle,
  input  logic signed [apwr_pkg::AngleW-1:0] target_angle,
  input  logic signed [apwr_pkg::AngleW-1:0] angle_rate,
  input  logic                              clear_loop,
  input  apwr_pkg::cfg_t                    cfg,
  output apwr_pkg::term_t                   term
);

  localparam int ProdW = apwr_pkg::AngleW + apwr_pkg::GainW + 1;

  logic signed [apwr_pkg::AngleW:0]   diff;
  logic signed [apwr_pkg::AngleW:0]   wrapped;
  logic signed [apwr_pkg::AngleW-1:0] err;
  logic signed [ProdW-1:0]            p_full;
  logic signed [ProdW-1:0]            i_full;
  logic signed [ProdW-1:0]            d_full;

  // Wrap target minus measured into [-pi, pi]; one step always suffices
  always_comb begin
    diff = {target_angle[apwr_pkg::AngleW-1], target_angle}
         - {measured_angle[apwr_pkg::AngleW-1], measured_angle};
    if (diff > apwr_pkg::AnglePi) begin
      wrapped = diff - apwr_pkg::AngleTwoPi;
    end else if (diff < -apwr_pkg::AnglePi) begin
      wrapped = diff + apwr_pkg::AngleTwoPi;
    end else begin
      wrapped = diff;
    end
    err = wrapped[apwr_pkg::AngleW-1:0];
  end

  // Unsigned Q8.8 gains times signed samples, exact
  always_comb begin
    p_full = $signed({1'b0, cfg.prop_gain}) * err;
    i_full = $signed({1'b0, cfg.integ_gain}) * err;
    d_full = $signed({1'b0, cfg.deriv_gain}) * angle_rate;
  end

  // Register; dropping the low bits is the floor shift
  always_ff @(posedge clk) begin
    if (en) begin
      term.clear_loop <= clear_loop;
      term.err        <= err;
      term.p_term     <= p_full[ProdW-1:apwr_pkg::GainFrac];
      term.i_term     <= i_full[ProdW-1:apwr_pkg::GainFrac];
      term.d_term     <= d_full[ProdW-1:apwr_pkg::GainFrac];
    end
  end

endmodule

### hw/rtl/apwr_integ.sv
// Integral accumulator, clamps and the result register.
// Depends on apwr_pkg.
module apwr_integ (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  apwr_pkg::term_t                    term,
  input  apwr_pkg::cfg_t                     cfg,
  output logic signed [apwr_pkg::DriveW-1:0] drive,
  output logic signed [apwr_pkg::AngleW-1:0] wrapped_error
);

  localparam int TW = apwr_pkg::TermW;
  localparam int DW = apwr_pkg::DriveW;
  localparam int IntW = DW + 1;
  localparam int SumW = DW + 2;

  logic signed [DW-1:0]   integral_sum;
  logic signed [IntW-1:0] integ_raw;
  logic signed [IntW-1:0] integ_lim;
  logic signed [IntW-1:0] integ_clamp;
  logic signed [SumW-1:0] total_raw;
  logic signed [SumW-1:0] out_lim;
  logic signed [SumW-1:0] total_clamp;

  // Accumulate and clamp the integral against the current limit
  always_comb begin
    integ_raw = {integral_sum[DW-1], integral_sum}
              + {{(IntW-TW){term.i_term[TW-1]}}, term.i_term};
    integ_lim = $signed({{(IntW-apwr_pkg::LimitW){1'b0}}, cfg.integral_limit});
    if (integ_raw > integ_lim) begin
      integ_clamp = integ_lim;
    end else if (integ_raw < -integ_lim) begin
      integ_clamp = -integ_lim;
    end else begin
      integ_clamp = integ_raw;
    end
  end

  // Sum P, I and D, clamp to the output limit
  always_comb begin
    total_raw = {{(SumW-TW){term.p_term[TW-1]}}, term.p_term}
              + {{(SumW-IntW){integ_clamp[IntW-1]}}, integ_clamp}
              + {{(SumW-TW){term.d_term[TW-1]}}, term.d_term};
    out_lim = $signed({{(SumW-apwr_pkg::LimitW){1'b0}}, cfg.output_limit});
    if (total_raw > out_lim) begin
      total_clamp = out_lim;
    end else if (total_raw < -out_lim) begin
      total_clamp = -out_lim;
    end else begin
      total_clamp = total_raw;
    end
  end

  // Hold the integral; a clear item zeroes it
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (en) begin
      if (term.clear_loop) begin
        integral_sum <= '0;
      end else begin
        integral_sum <= integ_clamp[DW-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en) begin
      if (term.clear_loop) begin
        drive         <= '0;
        wrapped_error <= '0;
      end else begin
        drive         <= total_clamp[DW-1:0];
        wrapped_error <= term.err;
      end
    end
  end

endmodule

### hw/rtl/angle_pid_with_wrap.sv
// Angle-loop PID with wrapped error, integral clamp and output clamp.
// Depends on apwr_pkg, apwr_term and apwr_integ.
//
// Use: write the gains and limits on the cfg port while the block is idle
// (cfg_we high for one cycle, cfg_index selects the register, cfg_data
// holds the value; unknown indexes are ignored). Samples enter on the
// s_axis channel, one result per sample leaves on m_axis in order.
// A sample passes through the input, product and result registers before
// it is shown on m_axis.
// Throughput: one sample per cycle unless m_axis stalls; the integral add
// and both clamps sit in one stage and close the accumulator loop.
// Three stages (input, product, result) each hold one item and each moves
// as soon as the stage after it is free, so input keeps being taken while
// a result waits; s_axis_tready falls only once all three are full and
// m_axis_tready is low.
// Reset: gains, limits and the integral go to zero, the pipeline empties.
// A sample with tuser set clears the integral and answers zero.
module angle_pid_with_wrap (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write port
  input  logic                        cfg_we,
  input  logic [apwr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [apwr_pkg::LimitW-1:0]  cfg_data,
  // Sample input
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // measured_angle, target_angle, angle_rate
  input  logic                        s_axis_tuser,  // clear_loop
  // Result output
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata   // drive, wrapped_error
);

  localparam int AW = apwr_pkg::AngleW;

  apwr_pkg::cfg_t  cfg;
  apwr_pkg::term_t term;

  logic          in_valid;
  logic          term_valid;
  logic          out_valid;
  logic          in_ready;
  logic          term_ready;
  logic          out_ready;
  logic          in_xfer;
  logic          term_en;
  logic          out_en;

  logic signed [AW-1:0] measured_angle;
  logic signed [AW-1:0] target_angle;
  logic signed [AW-1:0] angle_rate;
  logic                 clear_loop;

  logic signed [apwr_pkg::DriveW-1:0] drive;
  logic signed [AW-1:0]               wrapped_error;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        apwr_pkg::RegPropGain:  cfg.prop_gain      <= cfg_data[apwr_pkg::GainW-1:0];
        apwr_pkg::RegIntegGain: cfg.integ_gain     <= cfg_data[apwr_pkg::GainW-1:0];
        apwr_pkg::RegDerivGain: cfg.deriv_gain     <= cfg_data[apwr_pkg::GainW-1:0];
        apwr_pkg::RegIntegLim:  cfg.integral_limit <= cfg_data;
        apwr_pkg::RegOutLim:    cfg.output_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage advances when the one after it is empty or moving
  assign out_ready  = !out_valid || m_axis_tready;
  assign term_ready = !term_valid || out_ready;
  assign in_ready   = !in_valid || term_ready;
  assign s_axis_tready = in_ready;

  assign in_xfer = s_axis_tvalid && in_ready;
  assign term_en = in_valid && term_ready;
  assign out_en  = term_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      term_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid <= s_axis_tvalid;
      end
      if (term_ready) begin
        term_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= term_valid;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      measured_angle <= s_axis_tdata[AW-1:0];
      target_angle   <= s_axis_tdata[2*AW-1:AW];
      angle_rate     <= s_axis_tdata[3*AW-1:2*AW];
      clear_loop     <= s_axis_tuser;
    end
  end

  apwr_term u_term (
    .clk            (clk),
    .en             (term_en),
    .measured_angle (measured_angle),
    .target_angle   (target_angle),
    .angle_rate     (angle_rate),
    .clear_loop     (clear_loop),
    .cfg            (cfg),
    .term           (term)
  );

  apwr_integ u_integ (
    .clk           (clk),
    .rst           (rst),
    .en            (out_en),
    .term          (term),
    .cfg           (cfg),
    .drive         (drive),
    .wrapped_error (wrapped_error)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {wrapped_error, drive};

endmodule

### hw/rtl/apwr_checker.sv
// Port-level checks of the angle PID, bound to the top level.
// Depends on angle_pid_with_wrap_defines.svh and angle_pid_with_wrap.
`include "angle_pid_with_wrap_defines.svh"

module apwr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_we,
  input logic [apwr_pkg::CfgIdxW-1:0] cfg_index,
  input logic [apwr_pkg::LimitW-1:0]  cfg_data,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [47:0]                  s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [47:0]                  m_axis_tdata
);

  // A stalled result holds its value
  `APWR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Input backpressure only when the whole pipeline is full and stalled
  `APWR_ASSERT_NOW(a_ready_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

  // Wrapped error stays within plus or minus pi
  `APWR_ASSERT_NOW(a_err_range, m_axis_tvalid, ($signed(m_axis_tdata[47:32]) <= 16'sd25736) && ($signed(m_axis_tdata[47:32]) >= -16'sd25736), "wrapped error out of range")

  // Drive is clamped by a 31-bit limit and never reaches the most negative code
  `APWR_ASSERT_NOW(a_drive_range, m_axis_tvalid, m_axis_tdata[31:0] != 32'h8000_0000, "drive outside clamp range")

endmodule

bind angle_pid_with_wrap apwr_checker u_apwr_checker (.*);
